>>> rtl/core/palette_gray_scaler_2bit_top_assert.svh
// assertion macros for the palette gray scaler
`ifndef PALETTE_GRAY_SCALER_2BIT_TOP_ASSERT_SVH
`define PALETTE_GRAY_SCALER_2BIT_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define PGS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define PGS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define PGS_ASSERT_IMP(label, clk, rst, ante, cons)
`define PGS_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/core/pgs_pkg.sv
`timescale 1ns / 1ps
package pgs_pkg;
   typedef enum logic [1:0] {
      REQ_PALETTE = 2'd0,
      REQ_LINE    = 2'd1,
      REQ_ROW     = 2'd2,
      REQ_PIXEL   = 2'd3
   } req_kind_type;

   localparam int unsigned REG_SOURCE_WIDTH  = 0;
   localparam int unsigned REG_TARGET_WIDTH  = 1;
   localparam int unsigned REG_TARGET_HEIGHT = 2;
   localparam int unsigned REG_ROW_SCALE     = 3;
   localparam int unsigned REG_ORIGIN_X      = 4;
   localparam int unsigned REG_ORIGIN_Y      = 5;
   localparam int unsigned REG_SCREEN_COLS   = 6;
   localparam int unsigned REG_SCREEN_ROWS   = 7;

   localparam logic [7:0] GRAY_WHITE = 8'd255;

   // queue entry from front to back
   typedef struct packed {
      req_kind_type kind;
      logic [7:0]   entry_index;
      logic [7:0]   luma;
      logic [11:0]  coord;
      logic [13:0]  out_x;
      logic [13:0]  out_y;
      logic         written;
      logic [12:0]  frame_width;
   } work_type;

   function automatic logic [1:0] gray_to_level(input logic [7:0] g);
      logic [1:0] lvl;
      begin
         if (g >= 8'd255) lvl = 2'd3;
         else if (g >= 8'd170) lvl = 2'd2;
         else if (g >= 8'd85) lvl = 2'd1;
         else lvl = 2'd0;
         return lvl;
      end
   endfunction
endpackage

>>> rtl/core/pgs_front.sv
`timescale 1ns / 1ps
`include "palette_gray_scaler_2bit_top_assert.svh"
// classifies items: luma, row mapping, pixel clipping
module pgs_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_stall,
   input  logic [1:0]        in_type,
   input  logic [7:0]        in_index,
   input  logic [15:0]       in_color,
   input  logic              in_transp,
   input  logic [11:0]       in_coord,
   input  logic [12:0]       in_row_width,
   input  logic [11:0]       target_width,
   input  logic [11:0]       target_height,
   input  logic [27:0]       row_scale,
   input  logic [11:0]       origin_x,
   input  logic [11:0]       origin_y,
   input  logic [12:0]       screen_cols,
   input  logic [12:0]       screen_rows,
   output logic              q_valid,
   input  logic              q_stall,
   output pgs_pkg::work_type q_data
);
   logic              busy_ff, busy_in;
   logic [1:0]        type_ff;
   logic [7:0]        index_ff;
   logic [15:0]       color_ff;
   logic              transp_ff;
   logic [11:0]       coord_ff;
   logic [39:0]       prod_ff;
   logic              qv_ff, qv_in;
   pgs_pkg::work_type qd_ff, qd_in;
   logic [13:0]       last_row_ff, last_row_in;
   logic              live_ff, live_in;
   logic [13:0]       cur_row_ff, cur_row_in;
   logic [12:0]       fw_ff, fw_in;

   logic [12:0] dst;
   logic [14:0] oy;
   logic [14:0] ox;
   logic [15:0] luma_sum;
   logic        accept, finish;

   assign in_stall = busy_ff;
   assign accept   = in_valid && !busy_ff;
   assign finish   = busy_ff && !(qv_ff && q_stall);

   always_comb begin
      luma_sum = 16'((17'({color_ff[15:11], 3'b000}) * 17'd77
                    + 17'({color_ff[10:5], 2'b00}) * 17'd150
                    + 17'({color_ff[4:0], 3'b000}) * 17'd29) >> 8);
      dst = (prod_ff[39:16] > 24'd8191) ? 13'd8191 : prod_ff[28:16];
      oy  = 15'($signed(origin_y)) + 15'({2'b00, dst});
      ox  = 15'($signed(origin_x)) + 15'({3'b000, coord_ff});
   end

   always_comb begin
      busy_in     = busy_ff;
      qv_in       = qv_ff && q_stall;
      qd_in       = qd_ff;
      last_row_in = last_row_ff;
      live_in     = live_ff;
      cur_row_in  = cur_row_ff;
      fw_in       = fw_ff;
      if (accept) begin
         busy_in = 1'b1;
         if (pgs_pkg::req_kind_type'(in_type) == pgs_pkg::REQ_ROW) fw_in = in_row_width;
      end
      if (finish) begin
         busy_in           = 1'b0;
         qv_in             = 1'b1;
         qd_in             = '0;
         qd_in.kind        = pgs_pkg::req_kind_type'(type_ff);
         qd_in.entry_index = index_ff;
         qd_in.coord       = coord_ff;
         qd_in.luma        = transp_ff ? pgs_pkg::GRAY_WHITE : luma_sum[7:0];
         unique case (pgs_pkg::req_kind_type'(type_ff))
            pgs_pkg::REQ_ROW: begin
               cur_row_in  = oy[13:0];
               qd_in.out_y = oy[13:0];
               if ({1'b0, dst} == last_row_ff) begin
                  live_in = 1'b0;
               end else begin
                  last_row_in = {1'b0, dst};
                  live_in = (dst < {1'b0, target_height})
                     && ($signed(oy) < $signed({2'b00, screen_rows}));
               end
               qd_in.written = live_in;
            end
            pgs_pkg::REQ_PIXEL: begin
               qd_in.out_x       = ox[13:0];
               qd_in.out_y       = cur_row_ff;
               qd_in.frame_width = fw_ff;
               qd_in.written = live_ff && (coord_ff < target_width) && !ox[14]
                  && ($signed(ox) < $signed({2'b00, screen_cols}));
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         qv_ff       <= 1'b0;
         last_row_ff <= '1;
         live_ff     <= 1'b0;
         cur_row_ff  <= '0;
         fw_ff       <= '0;
      end else begin
         busy_ff     <= busy_in;
         qv_ff       <= qv_in;
         last_row_ff <= last_row_in;
         live_ff     <= live_in;
         cur_row_ff  <= cur_row_in;
         fw_ff       <= fw_in;
      end
   end

   always_ff @(posedge clock) begin
      qd_ff <= qd_in;
      if (accept) begin
         type_ff   <= in_type;
         index_ff  <= in_index;
         color_ff  <= in_color;
         transp_ff <= in_transp;
         coord_ff  <= in_coord;
         prod_ff   <= 40'(in_coord) * 40'(row_scale);
      end
   end

   assign q_valid = qv_ff;
   assign q_data  = qd_ff;

   `PGS_ASSERT_NXT(a_busy_after_accept, clock, reset, accept, busy_ff)
   `PGS_ASSERT_NXT(a_q_hold, clock, reset, qv_ff && q_stall, qv_ff && $stable(qd_ff))
   `PGS_ASSERT_IMP(a_no_busy_push_stall, clock, reset, finish, !(qv_ff && q_stall))
endmodule

>>> rtl/core/pgs_back.sv
`timescale 1ns / 1ps
`include "palette_gray_scaler_2bit_top_assert.svh"
// table writes and pixel lookups: divider, line store, gray table
module pgs_back #(
   parameter int PALETTE_SIZE = 256,
   parameter int LINE_DEPTH   = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_stall,
   input  pgs_pkg::work_type q_data,
   input  logic [11:0]       source_width,
   input  logic [11:0]       target_width,
   output logic              out_valid,
   input  logic              out_stall,
   output logic [13:0]       out_x,
   output logic [13:0]       out_y,
   output logic [1:0]        gray_level,
   output logic              out_written
);
   localparam int LW = $clog2(LINE_DEPTH);
   localparam int PW = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_DIV  = 5'b00010,
      ST_LINE = 5'b00100,
      ST_PAL  = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   logic [7:0] line_mem [LINE_DEPTH];
   logic [7:0] gray_mem [PALETTE_SIZE];

   state_type         st_ff, st_in;
   pgs_pkg::work_type w_ff;
   logic [23:0]       num_ff;
   logic [11:0]       rem_ff;
   logic [23:0]       quo_ff;
   logic [4:0]        cnt_ff;
   logic [7:0]        line_rd_ff;
   logic [7:0]        gray_rd_ff;
   logic              white_ff;
   logic              ov_ff;
   logic [13:0]       ox_ff, oy_ff;
   logic [1:0]        lvl_ff;
   logic              wr_ff;

   logic [12:0] rem_sh;
   logic        take;
   logic        out_free;

   assign out_free = !ov_ff || !out_stall;
   assign take     = q_valid && (st_ff == ST_IDLE);
   assign q_stall  = (st_ff != ST_IDLE);
   assign rem_sh   = {rem_ff, num_ff[23]};

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: if (q_valid) begin
            if (q_data.kind == pgs_pkg::REQ_PIXEL && q_data.written) st_in = ST_DIV;
            else st_in = ST_OUT;
         end
         ST_DIV:  if (cnt_ff == 5'd23) st_in = ST_LINE;
         ST_LINE: st_in = ST_PAL;
         ST_PAL:  st_in = ST_OUT;
         ST_OUT:  if (out_free) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (st_ff == ST_OUT && out_free) ov_ff <= 1'b1;
         else if (!out_stall) ov_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         w_ff   <= q_data;
         num_ff <= 24'(q_data.coord) * 24'(source_width);
         rem_ff <= '0;
         cnt_ff <= '0;
         if (q_data.kind == pgs_pkg::REQ_PALETTE && 32'(q_data.entry_index) < PALETTE_SIZE)
            gray_mem[PW'(q_data.entry_index)] <= q_data.luma;
         if (q_data.kind == pgs_pkg::REQ_LINE && 32'(q_data.coord) < LINE_DEPTH)
            line_mem[LW'(q_data.coord)] <= q_data.entry_index;
      end
      // restoring divide, one quotient bit per cycle
      if (st_ff == ST_DIV) begin
         num_ff <= {num_ff[22:0], 1'b0};
         cnt_ff <= cnt_ff + 5'd1;
         if (rem_sh >= {1'b0, target_width}) begin
            rem_ff <= 12'(rem_sh - {1'b0, target_width});
            quo_ff <= {quo_ff[22:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[11:0];
            quo_ff <= {quo_ff[22:0], 1'b0};
         end
      end
      if (st_ff == ST_LINE) begin
         line_rd_ff <= line_mem[LW'(quo_ff)];
         white_ff   <= (quo_ff >= 24'(w_ff.frame_width)) || (quo_ff >= 24'(LINE_DEPTH));
      end
      if (st_ff == ST_PAL) begin
         gray_rd_ff <= gray_mem[PW'(line_rd_ff)];
         if (32'(line_rd_ff) >= PALETTE_SIZE) white_ff <= 1'b1;
      end
      if (st_ff == ST_OUT && out_free) begin
         ox_ff  <= w_ff.out_x;
         oy_ff  <= w_ff.out_y;
         wr_ff  <= w_ff.written;
         lvl_ff <= (w_ff.kind == pgs_pkg::REQ_PIXEL && w_ff.written)
            ? pgs_pkg::gray_to_level(white_ff ? pgs_pkg::GRAY_WHITE : gray_rd_ff) : 2'd0;
      end
   end

   assign out_valid   = ov_ff;
   assign out_x       = ox_ff;
   assign out_y       = oy_ff;
   assign gray_level  = lvl_ff;
   assign out_written = wr_ff;

   `PGS_ASSERT_IMP(a_take_idle, clock, reset, take, !q_stall)
   `PGS_ASSERT_NXT(a_out_hold, clock, reset, ov_ff && out_stall, ov_ff && $stable(ox_ff))
   `PGS_ASSERT_NXT(a_div_len, clock, reset, st_ff == ST_DIV && cnt_ff == 5'd23, st_ff == ST_LINE)
endmodule

>>> rtl/core/palette_gray_scaler_2bit_top.sv
`timescale 1ns / 1ps
// Palette gray scaler: turns palette-indexed rows into 2-bit gray screen pixels.
// Each accepted word returns exactly one result word, in order. A palette, line or
// row word, or a pixel that is not written, skips the divide and memory reads in the
// back. A written pixel holds the back through the bit-serial column divide (24
// quotient bits, one per cycle), the line-store read, the gray-table read and the
// result register. The front takes a new word only after it has passed the last one
// on to the queue, and the back takes a queue entry only when it is idle.
// rsp_stall holds the result register and backs up through the queue to req_stall.
// The front registers the input and classifies it; a one-entry queue register
// decouples it from the back, which owns both memories.
module palette_gray_scaler_2bit_top #(
   parameter int PALETTE_SIZE = 256,
   parameter int LINE_DEPTH   = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_type,
   input  logic [7:0]         req_entry_index,
   input  logic [15:0]        req_color565,
   input  logic               req_is_transparent,
   input  logic [11:0]        req_coord,
   input  logic [12:0]        req_row_width,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [13:0] rsp_out_x,
   output logic signed [13:0] rsp_out_y,
   output logic [1:0]         rsp_gray_level,
   output logic               rsp_written,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   // configuration registers
   logic [11:0] src_w_ff, tgt_w_ff, tgt_h_ff, org_x_ff, org_y_ff;
   logic [27:0] scale_ff;
   logic [12:0] scr_c_ff, scr_r_ff;
   logic        csr_wr;
   logic [2:0]  reg_sel;

   logic              q_valid, q_stall;
   pgs_pkg::work_type q_data;
   logic [13:0]       ox_w, oy_w;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= 12'd1;
         tgt_w_ff <= 12'd1;
         tgt_h_ff <= 12'd0;
         scale_ff <= 28'd65536;
         org_x_ff <= 12'd0;
         org_y_ff <= 12'd0;
         scr_c_ff <= 13'd480;
         scr_r_ff <= 13'd800;
      end else if (csr_wr) begin
         unique case (32'(reg_sel))
            pgs_pkg::REG_SOURCE_WIDTH:  src_w_ff <= csr_pwdata[11:0];
            pgs_pkg::REG_TARGET_WIDTH:  tgt_w_ff <= csr_pwdata[11:0];
            pgs_pkg::REG_TARGET_HEIGHT: tgt_h_ff <= csr_pwdata[11:0];
            pgs_pkg::REG_ROW_SCALE:     scale_ff <= csr_pwdata[27:0];
            pgs_pkg::REG_ORIGIN_X:      org_x_ff <= csr_pwdata[11:0];
            pgs_pkg::REG_ORIGIN_Y:      org_y_ff <= csr_pwdata[11:0];
            pgs_pkg::REG_SCREEN_COLS:   scr_c_ff <= csr_pwdata[12:0];
            pgs_pkg::REG_SCREEN_ROWS:   scr_r_ff <= csr_pwdata[12:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      unique case (32'(reg_sel))
         pgs_pkg::REG_SOURCE_WIDTH:  csr_prdata = 32'(src_w_ff);
         pgs_pkg::REG_TARGET_WIDTH:  csr_prdata = 32'(tgt_w_ff);
         pgs_pkg::REG_TARGET_HEIGHT: csr_prdata = 32'(tgt_h_ff);
         pgs_pkg::REG_ROW_SCALE:     csr_prdata = 32'(scale_ff);
         pgs_pkg::REG_ORIGIN_X:      csr_prdata = 32'(org_x_ff);
         pgs_pkg::REG_ORIGIN_Y:      csr_prdata = 32'(org_y_ff);
         pgs_pkg::REG_SCREEN_COLS:   csr_prdata = 32'(scr_c_ff);
         pgs_pkg::REG_SCREEN_ROWS:   csr_prdata = 32'(scr_r_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   // front: classify, map rows, clip pixels; frame width travels with each pixel
   pgs_front u_front (
      .clock, .reset,
      .in_valid(req_valid), .in_stall(req_stall),
      .in_type(req_type), .in_index(req_entry_index), .in_color(req_color565),
      .in_transp(req_is_transparent), .in_coord(req_coord), .in_row_width(req_row_width),
      .target_width(tgt_w_ff), .target_height(tgt_h_ff), .row_scale(scale_ff),
      .origin_x(org_x_ff), .origin_y(org_y_ff),
      .screen_cols(scr_c_ff), .screen_rows(scr_r_ff),
      .q_valid, .q_stall, .q_data
   );

   // back: memories, column divide, level
   pgs_back #(.PALETTE_SIZE(PALETTE_SIZE), .LINE_DEPTH(LINE_DEPTH)) u_back (
      .clock, .reset,
      .q_valid, .q_stall, .q_data,
      .source_width(src_w_ff), .target_width(tgt_w_ff),
      .out_valid(rsp_valid), .out_stall(rsp_stall),
      .out_x(ox_w), .out_y(oy_w), .gray_level(rsp_gray_level), .out_written(rsp_written)
   );

   assign rsp_out_x = $signed(ox_w);
   assign rsp_out_y = $signed(oy_w);
endmodule
